>>> sv/mfr_pkg.sv
// Package for the motor frame receiver: framing bytes, command codes,
// status bits, message kinds and the byte-wide CRC-8 update.
// No dependencies.
package mfr_pkg;

  // Framing
  localparam logic [7:0] StartByte = 8'h53;  // 'S'
  localparam logic [7:0] EndByte   = 8'h45;  // 'E'
  localparam logic [7:0] MinLength = 8'd4;   // length, node, command, crc

  // CRC-8, reflected (LSB-first) form; the shift constant 0xD5 is polynomial 0xAB reflected
  localparam logic [7:0] CrcPoly = 8'hD5;
  localparam logic [7:0] CrcInit = 8'hFF;

  // Command codes
  localparam logic [7:0] CmdPosition = 8'h01;
  localparam logic [7:0] CmdWriteAck = 8'h02;
  localparam logic [7:0] CmdStatus   = 8'h05;

  // Object index bytes that mark a position reply
  localparam logic [7:0] PosIndexLo = 8'h64;
  localparam logic [7:0] PosIndexHi = 8'h60;
  localparam logic [7:0] PosSubIdx  = 8'h00;

  // Status word bits
  localparam logic [15:0] StatusPosAccepted = 16'h1000;
  localparam logic [15:0] StatusTargetReach = 16'h0400;
  localparam logic [15:0] StatusEnableMask  = 16'h0007;

  // Default number of stored data bytes
  localparam int unsigned KeptDataBytesDef = 7;

  typedef enum logic [1:0] {
    KindPosition = 2'd0,
    KindWriteAck = 2'd1,
    KindStatus   = 2'd2,
    KindUnknown  = 2'd3
  } msg_kind_e;

  // One byte through the CRC, bit at a time (eight narrow steps)
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] r;
    r = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      if (r[0]) begin
        r = (r >> 1) ^ CrcPoly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

>>> sv/motor_frame_receiver_core.sv
// Motor telegram deframer: start byte, length, node, command, data, CRC-8, end byte.
// Depends on mfr_pkg (constants, message kinds, CRC update).
//
// A result is valid the cycle after its end byte is accepted.
// Throughput: one received byte per cycle; the input stalls only in the end phase
// while the previous result is still waiting to be taken.
// Reset (rst_ni, async, low): parser waits for a start byte, position, status and
// sticky flags clear, no result pending. Stored data bytes are not cleared.
module motor_frame_receiver_core #(
  parameter int unsigned KEPT_DATA_BYTES = mfr_pkg::KeptDataBytesDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Byte requests
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         rx_byte_i,
  // Frame results
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [7:0]         command_code_o,
  output logic [7:0]         node_number_o,
  output logic [7:0]         data_count_o,
  output logic [1:0]         message_kind_o,
  output logic signed [31:0] position_o,
  output logic [15:0]        status_word_o,
  output logic               homing_done_o,
  output logic               position_accepted_o,
  output logic               target_hit_o,
  output logic               drive_disabled_o
);
  import mfr_pkg::*;

  typedef enum logic [2:0] {
    PhIdle = 3'd0,
    PhLen  = 3'd1,
    PhNode = 3'd2,
    PhCmd  = 3'd3,
    PhData = 3'd4,
    PhCrc  = 3'd5,
    PhEnd  = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [7:0]  crc_q, crc_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  node_q, node_d;
  logic [7:0]  cmd_q, cmd_d;
  logic [7:0]  kept_q [KEPT_DATA_BYTES];
  logic signed [31:0] pos_q, pos_d;
  logic [15:0] status_q, status_d;
  logic        homing_q, homing_d;
  logic        posacc_q, posacc_d;
  logic        target_q, target_d;

  logic        out_valid_q;
  logic [7:0]  out_cmd_q, out_node_q, out_len_q;
  logic [1:0]  out_kind_q;
  logic        out_dis_q;

  logic        in_accept;
  logic        res_load;
  logic [7:0]  crc_next;
  msg_kind_e   kind;
  logic [15:0] sw;
  logic        disabled;

  // Hold the byte stream only when an end byte could not place its result
  assign in_ready_o = (phase_q != PhEnd) || !out_valid_q || out_ready_i;
  assign in_accept  = in_valid_i && in_ready_o;
  assign res_load   = in_accept && (phase_q == PhEnd) && (rx_byte_i == EndByte);
  assign crc_next   = crc8_update(crc_q, rx_byte_i);

  // Frame decode from the stored data bytes
  assign sw = {kept_q[1], kept_q[0]};
  always_comb begin
    if (cmd_q == CmdPosition && kept_q[0] == PosIndexLo && kept_q[1] == PosIndexHi
        && kept_q[2] == PosSubIdx) begin
      kind = KindPosition;
    end else if (cmd_q == CmdWriteAck) begin
      kind = KindWriteAck;
    end else if (cmd_q == CmdStatus) begin
      kind = KindStatus;
    end else begin
      kind = KindUnknown;
    end
  end
  assign disabled = (kind == KindStatus) && ((sw & StatusEnableMask) != StatusEnableMask);

  // Parser next state
  always_comb begin
    phase_d  = phase_q;
    crc_d    = crc_q;
    len_d    = len_q;
    count_d  = count_q;
    node_d   = node_q;
    cmd_d    = cmd_q;
    pos_d    = pos_q;
    status_d = status_q;
    homing_d = homing_q;
    posacc_d = posacc_q;
    target_d = target_q;
    if (in_accept) begin
      case (phase_q)
        PhIdle: begin
          if (rx_byte_i == StartByte) begin
            phase_d = PhLen;
            crc_d   = CrcInit;
          end
        end
        PhLen: begin
          if (rx_byte_i < MinLength) begin
            phase_d = PhIdle;
          end else begin
            len_d   = rx_byte_i - MinLength;
            crc_d   = crc_next;
            phase_d = PhNode;
          end
        end
        PhNode: begin
          node_d  = rx_byte_i;
          crc_d   = crc_next;
          phase_d = PhCmd;
        end
        PhCmd: begin
          cmd_d   = rx_byte_i;
          count_d = '0;
          crc_d   = crc_next;
          phase_d = (len_q == '0) ? PhCrc : PhData;
        end
        PhData: begin
          count_d = count_q + 8'd1;
          crc_d   = crc_next;
          if (count_d >= len_q) begin
            phase_d = PhCrc;
          end
        end
        PhCrc: begin
          phase_d = (crc_q == rx_byte_i) ? PhEnd : PhIdle;
        end
        PhEnd: begin
          phase_d = PhIdle;
          if (rx_byte_i == EndByte) begin
            // Good frame: update kept position, status and sticky flags
            if (kind == KindPosition) begin
              pos_d = {kept_q[6], kept_q[5], kept_q[4], kept_q[3]};
            end else if (kind == KindStatus) begin
              status_d = sw;
              if ((sw & StatusPosAccepted) != '0 && (sw & StatusTargetReach) != '0) begin
                homing_d = 1'b1;
              end
              if ((sw & StatusPosAccepted) != '0) begin
                posacc_d = 1'b1;
              end
              if ((sw & StatusTargetReach) != '0) begin
                target_d = 1'b1;
              end
            end
          end
        end
        default: begin
          phase_d = PhIdle;
        end
      endcase
    end
  end

  // Parser and kept-value registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhIdle;
      crc_q    <= CrcInit;
      len_q    <= '0;
      count_q  <= '0;
      node_q   <= '0;
      cmd_q    <= '0;
      pos_q    <= '0;
      status_q <= '0;
      homing_q <= 1'b0;
      posacc_q <= 1'b0;
      target_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      len_q    <= len_d;
      count_q  <= count_d;
      node_q   <= node_d;
      cmd_q    <= cmd_d;
      pos_q    <= pos_d;
      status_q <= status_d;
      homing_q <= homing_d;
      posacc_q <= posacc_d;
      target_q <= target_d;
    end
  end

  // Data byte store, one register per slot
  for (genvar i = 0; i < KEPT_DATA_BYTES; i++) begin : g_kept
    always_ff @(posedge clk_i) begin
      if (in_accept && phase_q == PhData && count_q == 8'(i)) begin
        kept_q[i] <= rx_byte_i;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      out_cmd_q  <= cmd_q;
      out_node_q <= node_q;
      out_len_q  <= len_q;
      out_kind_q <= kind;
      out_dis_q  <= disabled;
    end
  end

  // Kept values change only when a result loads, so they drive the outputs directly
  assign out_valid_o         = out_valid_q;
  assign command_code_o      = out_cmd_q;
  assign node_number_o       = out_node_q;
  assign data_count_o        = out_len_q;
  assign message_kind_o      = out_kind_q;
  assign drive_disabled_o    = out_dis_q;
  assign position_o          = pos_q;
  assign status_word_o       = status_q;
  assign homing_done_o       = homing_q;
  assign position_accepted_o = posacc_q;
  assign target_hit_o        = target_q;

`ifndef ASSERT_OFF
  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_load |-> (!out_valid_q || out_ready_i))
    else $error("result overwritten while pending");

  // A result only follows an accepted end byte in the end phase
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_accept && phase_q == PhEnd && rx_byte_i == EndByte))
    else $error("result without end byte");

  // Drive-disabled only reported on status frames
  a_disabled_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_dis_q) |-> (out_kind_q == KindStatus))
    else $error("drive disabled on non-status frame");

  // Homing implies both component flags
  a_homing_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    homing_q |-> (posacc_q && target_q))
    else $error("homing flag without its components");

  // Sticky flags never clear outside reset
  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$fell(homing_q) && !$fell(posacc_q) && !$fell(target_q))
    else $error("sticky flag cleared");
`endif

endmodule

>>> verif/motor_frame_receiver_core_test.sv
`timescale 1ns / 1ps
// Testbench for motor_frame_receiver_core: feeds a byte stream of motor telegrams,
// predicts each decoded frame result and checks it field by field.
// Depends on mfr_pkg and the motor_frame_receiver_core RTL.
module motor_frame_receiver_core_test;
  import mfr_pkg::*;

  localparam int unsigned RxByteTarget = 750;
  localparam int unsigned CycleLimit   = 200000;
  localparam int unsigned KeptBytes    = KeptDataBytesDef;
  localparam int unsigned KeptIdxW     = $clog2(KeptBytes);

  // Receiver stall patterns
  localparam int unsigned ReadyAlways   = 0;
  localparam int unsigned ReadyHalf     = 1;
  localparam int unsigned ReadySparse   = 2;
  localparam int unsigned ReadyPeriodic = 3;

  typedef enum logic [2:0] {
    PhWaitStart, PhLength, PhNode, PhCommand, PhData, PhCrc, PhEnd
  } rx_phase_e;

  typedef struct packed {
    logic [7:0]  cmd_byte;
    logic [7:0]  node_num;
    logic [7:0]  dlen;
    msg_kind_e   kind;
    logic [31:0] position;
    logic [15:0] status;
    logic        homing;
    logic        posacc;
    logic        target;
    logic        disabled;
  } frame_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [7:0]         rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [7:0]         command_code_o;
  logic [7:0]         node_number_o;
  logic [7:0]         data_count_o;
  logic [1:0]         message_kind_o;
  logic signed [31:0] position_o;
  logic [15:0]        status_word_o;
  logic               homing_done_o;
  logic               position_accepted_o;
  logic               target_hit_o;
  logic               drive_disabled_o;

  motor_frame_receiver_core u_top (.*);

  // Stimulus and expected results
  logic [7:0]    rx_pending[$];
  logic [7:0]    frame_body[$];
  frame_result_t frame_results_due[$];
  frame_result_t want;
  int            mismatch_count;
  int            cycle_count;

  // Deframer model state
  rx_phase_e   rx_phase;
  logic [7:0]  crc_acc;
  logic [7:0]  frame_dlen;
  logic [7:0]  frame_node;
  logic [7:0]  frame_cmd;
  int          data_seen;
  logic [7:0]  kept_data[KeptBytes];
  logic [31:0] held_position;
  logic [15:0] held_status;
  logic        seen_homing;
  logic        seen_posacc;
  logic        seen_target;

  // Driver and receiver pacing
  bit byte_taken;
  int burst_left;
  int gap_left;
  int stall_mode;
  int stall_left;

  // Reflected CRC-8, one bit per pass
  function automatic logic [7:0] crc_fold(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    r = acc ^ b;
    repeat (8) r = {1'b0, r[7:1]} ^ (r[0] ? CrcPoly : 8'h00);
    return r;
  endfunction

  // Wrap frame_body into a telegram, optionally with a broken CRC or end byte
  task automatic queue_frame(input logic [7:0] node_b, input logic [7:0] cmd_b,
                             input bit bad_crc, input bit bad_end);
    logic [7:0] len_b;
    logic [7:0] crc_b;
    logic [7:0] tail_b;
    len_b = 8'(frame_body.size()) + MinLength;
    crc_b = crc_fold(CrcInit, len_b);
    crc_b = crc_fold(crc_b, node_b);
    crc_b = crc_fold(crc_b, cmd_b);
    rx_pending.push_back(StartByte);
    rx_pending.push_back(len_b);
    rx_pending.push_back(node_b);
    rx_pending.push_back(cmd_b);
    foreach (frame_body[i]) begin
      crc_b = crc_fold(crc_b, frame_body[i]);
      rx_pending.push_back(frame_body[i]);
    end
    if (bad_crc) crc_b = crc_b ^ 8'($urandom_range(1, 255));
    rx_pending.push_back(crc_b);
    tail_b = EndByte;
    while (bad_end && tail_b == EndByte) tail_b = 8'($urandom_range(0, 255));
    rx_pending.push_back(tail_b);
  endtask

  // Advance the deframer model by one accepted byte
  task automatic parse_rx_byte(input logic [7:0] b);
    frame_result_t res;
    logic [15:0]   sw;
    case (rx_phase)
      PhWaitStart: begin
        if (b == StartByte) begin
          rx_phase = PhLength;
          crc_acc  = CrcInit;
        end
      end
      PhLength: begin
        if (b < MinLength) begin
          rx_phase = PhWaitStart;
        end else begin
          frame_dlen = b - MinLength;
          crc_acc    = crc_fold(crc_acc, b);
          rx_phase   = PhNode;
        end
      end
      PhNode: begin
        frame_node = b;
        crc_acc    = crc_fold(crc_acc, b);
        rx_phase   = PhCommand;
      end
      PhCommand: begin
        frame_cmd = b;
        data_seen = 0;
        crc_acc   = crc_fold(crc_acc, b);
        rx_phase  = (frame_dlen == 0) ? PhCrc : PhData;
      end
      PhData: begin
        if (data_seen < KeptBytes) kept_data[KeptIdxW'(data_seen)] = b;
        data_seen++;
        crc_acc = crc_fold(crc_acc, b);
        if (data_seen >= frame_dlen) rx_phase = PhCrc;
      end
      PhCrc: begin
        rx_phase = (b == crc_acc) ? PhEnd : PhWaitStart;
      end
      PhEnd: begin
        rx_phase = PhWaitStart;
        if (b == EndByte) begin
          res.disabled = 1'b0;
          if (frame_cmd == CmdPosition && kept_data[0] == PosIndexLo &&
              kept_data[1] == PosIndexHi && kept_data[2] == PosSubIdx) begin
            res.kind      = KindPosition;
            held_position = {kept_data[6], kept_data[5], kept_data[4], kept_data[3]};
          end else if (frame_cmd == CmdWriteAck) begin
            res.kind = KindWriteAck;
          end else if (frame_cmd == CmdStatus) begin
            sw          = {kept_data[1], kept_data[0]};
            res.kind    = KindStatus;
            held_status = sw;
            if ((sw & StatusPosAccepted) != 0 && (sw & StatusTargetReach) != 0) seen_homing = 1'b1;
            if ((sw & StatusPosAccepted) != 0) seen_posacc = 1'b1;
            if ((sw & StatusTargetReach) != 0) seen_target = 1'b1;
            res.disabled = (sw & StatusEnableMask) != StatusEnableMask;
          end else begin
            res.kind = KindUnknown;
          end
          res.cmd_byte = frame_cmd;
          res.node_num = frame_node;
          res.dlen     = frame_dlen;
          res.position = held_position;
          res.status   = held_status;
          res.homing   = seen_homing;
          res.posacc   = seen_posacc;
          res.target   = seen_target;
          frame_results_due.push_back(res);
        end
      end
      default: rx_phase = PhWaitStart;
    endcase
  endtask

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, exp_v, got_v);
      mismatch_count++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Byte request driver: bursts with random gaps
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid_i || byte_taken) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          in_valid_i <= 1'b1;
          rx_byte_i  <= rx_pending.pop_front();
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid_i <= 1'b0;
        end
      end
      byte_taken = 1'b0;
    end
  end

  // Result receiver: switches between randomly chosen stall patterns
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(ReadyAlways, ReadyPeriodic);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      ReadyAlways: out_ready_i <= 1'b1;
      ReadyHalf:   out_ready_i <= 1'($urandom_range(0, 1));
      ReadySparse: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:     out_ready_i <= (stall_left[4:3] != 2'b11);
    endcase
  end

  // Monitor: check taken results first, then feed the taken byte to the model
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (frame_results_due.size() == 0) begin
          $display("%0t: frame result with none expected, expected none, got command %h",
                   $time, command_code_o);
          mismatch_count++;
        end else begin
          want = frame_results_due.pop_front();
          check_field("command_code", 32'(want.cmd_byte), 32'(command_code_o));
          check_field("node_number", 32'(want.node_num), 32'(node_number_o));
          check_field("data_count", 32'(want.dlen), 32'(data_count_o));
          check_field("message_kind", 32'(want.kind), 32'(message_kind_o));
          check_field("position", want.position, position_o);
          check_field("status_word", 32'(want.status), 32'(status_word_o));
          check_field("homing_done", 32'(want.homing), 32'(homing_done_o));
          check_field("position_accepted", 32'(want.posacc), 32'(position_accepted_o));
          check_field("target_hit", 32'(want.target), 32'(target_hit_o));
          check_field("drive_disabled", 32'(want.disabled), 32'(drive_disabled_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        byte_taken = 1'b1;
        parse_rx_byte(rx_byte_i);
      end
    end
  end

  // Run limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin
    int         pick;
    int         flaw;
    logic [15:0] sw;
    logic [7:0]  cmd_b;

    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    rx_byte_i      = 8'h00;
    out_ready_i    = 1'b0;
    mismatch_count = 0;
    byte_taken     = 1'b0;
    burst_left     = 0;
    gap_left       = 0;
    stall_mode     = ReadyAlways;
    stall_left     = 0;
    rx_phase       = PhWaitStart;
    crc_acc        = CrcInit;
    frame_dlen     = 8'h00;
    frame_node     = 8'h00;
    frame_cmd      = 8'h00;
    data_seen      = 0;
    held_position  = 32'h0;
    held_status    = 16'h0;
    seen_homing    = 1'b0;
    seen_posacc    = 1'b0;
    seen_target    = 1'b0;

    // Directed: full position reply (fills every stored byte, negative position)
    frame_body = '{PosIndexLo, PosIndexHi, PosSubIdx, 8'h01, 8'h02, 8'h03, 8'h80};
    queue_frame(8'hFF, CmdPosition, 1'b0, 1'b0);
    // empty data area: CRC follows the command byte
    frame_body.delete();
    queue_frame(8'h00, CmdWriteAck, 1'b0, 1'b0);
    // length just below the minimum aborts
    rx_pending.push_back(StartByte);
    rx_pending.push_back(MinLength - 8'd1);
    // status word: target reached only, drive enabled
    frame_body = '{8'h07, 8'h04};
    queue_frame(8'h80, CmdStatus, 1'b0, 1'b0);

    // Random: mostly well-formed telegrams, some noise and broken frames
    while (rx_pending.size() < RxByteTarget) begin
      flaw = $urandom_range(0, 99);
      if (flaw >= 80 && flaw < 90) begin
        repeat ($urandom_range(1, 6)) rx_pending.push_back(8'($urandom_range(0, 255)));
      end else if (flaw >= 90) begin
        rx_pending.push_back(StartByte);
        rx_pending.push_back(8'($urandom_range(0, MinLength - 1)));
      end
      frame_body.delete();
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        cmd_b      = CmdPosition;
        frame_body = '{PosIndexLo, PosIndexHi, PosSubIdx};
        repeat ($urandom_range(4, 7)) frame_body.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 50) begin
        cmd_b = CmdStatus;
        sw    = 16'($urandom_range(0, 65535));
        if ($urandom_range(0, 1) == 1) sw = sw | StatusEnableMask;
        frame_body = '{sw[7:0], sw[15:8]};
        repeat ($urandom_range(0, 5)) frame_body.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 60) begin
        cmd_b = CmdWriteAck;
        repeat ($urandom_range(0, 8)) frame_body.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 70) begin
        // position command with a damaged object index
        cmd_b      = CmdPosition;
        frame_body = '{PosIndexLo, PosIndexHi, PosSubIdx};
        frame_body[$urandom_range(0, 2)] = 8'($urandom_range(0, 255));
        repeat ($urandom_range(0, 6)) frame_body.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 78) begin
        // short frame decodes partly from bytes left by earlier frames
        cmd_b = ($urandom_range(0, 1) == 1) ? CmdPosition : CmdStatus;
        repeat ($urandom_range(0, 2)) frame_body.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        cmd_b = 8'($urandom_range(0, 255));
        repeat ($urandom_range(0, 12)) frame_body.push_back(8'($urandom_range(0, 255)));
      end else begin
        // long data area, only the first bytes are stored
        cmd_b = pick[0] ? CmdStatus : 8'($urandom_range(0, 255));
        repeat ($urandom_range(20, 251)) frame_body.push_back(8'($urandom_range(0, 255)));
      end
      queue_frame(8'($urandom_range(0, 255)), cmd_b, flaw < 8, flaw >= 8 && flaw < 14);
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (rx_pending.size() != 0 || in_valid_i) @(posedge clk_i);
    while (frame_results_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> files.f
sv/mfr_pkg.sv
sv/motor_frame_receiver_core.sv
verif/motor_frame_receiver_core_test.sv
